// ===== src/ypc_pkg.sv =====
package ypc_pkg;

   // defaults for the top-level parameters
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int POSITION_WIDTH_DEF = 32;

   // item kinds
   localparam logic [2:0] KIND_ROTATE   = 3'd0;
   localparam logic [2:0] KIND_FORWARD  = 3'd1;
   localparam logic [2:0] KIND_BACKWARD = 3'd2;
   localparam logic [2:0] KIND_LEFT     = 3'd3;
   localparam logic [2:0] KIND_RIGHT    = 3'd4;

   // register indexes
   localparam logic CSR_SENSITIVITY = 1'b0;
   localparam logic CSR_SPEED       = 1'b1;

   // register reset values
   localparam logic [15:0] SENSITIVITY_RESET = 16'd6554;
   localparam logic [15:0] SPEED_RESET       = 16'd640;

   // angles in q9.16 degrees
   localparam logic [24:0]        HEADING_RESET = 25'd17694720;
   localparam logic signed [26:0] DEG90         = 27'sd5898240;
   localparam logic signed [26:0] DEG180        = 27'sd11796480;
   localparam logic signed [26:0] DEG360        = 27'sd23592960;
   localparam logic signed [33:0] ELEV_MAX      = 34'sd5898240;

   // cordic start value (gain compensated, q2.30)
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   // unit length in q1.14
   localparam logic signed [15:0] VEC_ONE = 16'sd16384;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic [15:0]        step_time;
   } ypc_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } ypc_rsp_type;

   // atan(2^-i) in q16 degrees
   function automatic logic [22:0] atan_q16(input logic [4:0] idx);
      logic [22:0] res;
      case (idx)
         5'd0:    res = 23'd2949120;
         5'd1:    res = 23'd1740967;
         5'd2:    res = 23'd919879;
         5'd3:    res = 23'd466945;
         5'd4:    res = 23'd234379;
         5'd5:    res = 23'd117304;
         5'd6:    res = 23'd58666;
         5'd7:    res = 23'd29335;
         5'd8:    res = 23'd14668;
         5'd9:    res = 23'd7334;
         5'd10:   res = 23'd3667;
         5'd11:   res = 23'd1833;
         5'd12:   res = 23'd917;
         5'd13:   res = 23'd458;
         5'd14:   res = 23'd229;
         5'd15:   res = 23'd115;
         5'd16:   res = 23'd57;
         5'd17:   res = 23'd29;
         5'd18:   res = 23'd14;
         5'd19:   res = 23'd7;
         5'd20:   res = 23'd4;
         5'd21:   res = 23'd2;
         5'd22:   res = 23'd1;
         default: res = 23'd0;
      endcase
      return res;
   endfunction

endpackage

// ===== src/yaw_pitch_camera_update.sv =====
// Euler-angle fly camera with fixed-point state.
// Input channel req_*: one item per valid/ready handshake. A rotate item
// turns the camera by the mouse offsets times look_sensitivity; a move item
// moves the position along +-front or +-right by move_speed times step_time.
// Result channel rsp_*: exactly one item per input item, carrying the
// position (low 32 bits) and the front, right and up vectors after the update.
// Register port csr_*: index 0 look_sensitivity, index 1 move_speed; write
// only while no item is in flight.
// One arithmetic unit (a 33x33 multiplier with the cordic, square root and
// divider steps around it) is stepped by a sequencer, one item at a time.
// A rotate makes two cordic runs and three normalisations, each of them
// mostly the 32-step square root and three 15-step divisions. A move
// updates the three position components in turn; an unused kind goes
// straight to the result. req_ready is high only while the sequencer is idle.
// The result sits in an output register; a new item may be taken while it
// waits, but the next result is held back until rsp_ready has taken it.
// Reset: heading 270 degrees, elevation 0, position 0, front (0,0,-1),
// right (1,0,0), up (0,1,0), registers at their reset values.
module yaw_pitch_camera_update #(
   parameter int CORDIC_STEPS   = ypc_pkg::CORDIC_STEPS_DEF,
   parameter int POSITION_WIDTH = ypc_pkg::POSITION_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ypc_pkg::ypc_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ypc_pkg::ypc_rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);
   import ypc_pkg::*;

   localparam int SW = ((POSITION_WIDTH > 26) ? POSITION_WIDTH : 26) + 2;
   localparam logic signed [SW-1:0] PMAX =
      {{(SW-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] PMIN = ~PMAX;

   typedef enum logic [26:0] {
      ST_IDLE      = 27'd1 << 0,
      ST_DXM       = 27'd1 << 1,
      ST_DYM       = 27'd1 << 2,
      ST_WRAP_INIT = 27'd1 << 3,
      ST_WRAP      = 27'd1 << 4,
      ST_CINIT     = 27'd1 << 5,
      ST_CIT       = 27'd1 << 6,
      ST_CEND      = 27'd1 << 7,
      ST_FMUL0     = 27'd1 << 8,
      ST_FMUL1     = 27'd1 << 9,
      ST_FSET      = 27'd1 << 10,
      ST_NSQ       = 27'd1 << 11,
      ST_NACC      = 27'd1 << 12,
      ST_SQRT      = 27'd1 << 13,
      ST_DINIT     = 27'd1 << 14,
      ST_DIV       = 27'd1 << 15,
      ST_DEND      = 27'd1 << 16,
      ST_RSET      = 27'd1 << 17,
      ST_UMUL0     = 27'd1 << 18,
      ST_UMUL1     = 27'd1 << 19,
      ST_UMUL2     = 27'd1 << 20,
      ST_UMUL3     = 27'd1 << 21,
      ST_USET      = 27'd1 << 22,
      ST_MV0       = 27'd1 << 23,
      ST_MV1       = 27'd1 << 24,
      ST_MV2       = 27'd1 << 25,
      ST_DONE      = 27'd1 << 26
   } state_type;

   typedef enum logic [1:0] {
      NV_FRONT = 2'd0,
      NV_RIGHT = 2'd1,
      NV_UP    = 2'd2
   } nvec_type;

   // control
   state_type state_ff, state_in;
   logic [4:0] cnt_ff;
   logic [1:0] k_ff;
   logic       sel_ff;
   logic       neg_ff;
   nvec_type   nsel_ff;
   logic       rsp_valid_ff;

   // architectural state
   logic [15:0]                      sens_ff;
   logic [15:0]                      speed_ff;
   logic [24:0]                      heading_ff;
   logic signed [23:0]               elev_ff;
   logic signed [POSITION_WIDTH-1:0] pos_ff [3];
   logic signed [15:0]               front_ff [3];
   logic signed [15:0]               right_ff [3];
   logic signed [15:0]               up_ff [3];

   // work registers
   ypc_req_type        req_ff;
   ypc_rsp_type        rsp_ff;
   logic signed [65:0] prod_ff;
   logic signed [33:0] ang_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [26:0] z_ff;
   logic signed [33:0] cos_h_ff, sin_h_ff, cos_e_ff, sin_e_ff;
   logic signed [32:0] raw_ff [3];
   logic [63:0]        acc_ff;
   logic [63:0]        root_ff;
   logic [46:0]        rem_ff;
   logic [14:0]        quo_ff;

   // combinational
   logic signed [32:0] mul_a, mul_b;
   logic signed [33:0] ang_in, wrap_d, wrap_sub;
   logic signed [33:0] elev_sum, elev_in;
   logic signed [26:0] red_a0, red_a1, red_in;
   logic               red_neg;
   logic signed [33:0] cx_dx, cx_dy;
   logic signed [26:0] c_at;
   logic signed [32:0] raw_k, mag_k;
   logic [63:0]        sq_bit, sq_try, acc_in;
   logic [32:0]        root_n;
   logic [46:0]        div_d;
   logic [15:0]        q_clamp;
   logic signed [15:0] norm_out;
   logic signed [15:0] mv_dir;
   logic               mv_neg;
   logic signed [65:0] mv_rnd;
   logic signed [26:0] mv_delta;
   logic signed [SW-1:0] mv_sum, pos_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mv_dir = (req_ff.kind == KIND_FORWARD || req_ff.kind == KIND_BACKWARD) ?
               front_ff[k_ff] : right_ff[k_ff];
      mv_neg = (req_ff.kind == KIND_BACKWARD || req_ff.kind == KIND_LEFT);
      raw_k  = raw_ff[k_ff];
      mag_k  = raw_k[32] ? -raw_k : raw_k;
      case (state_ff)
         ST_DXM: begin
            mul_a = 33'(req_ff.x_offset);
            mul_b = {17'd0, sens_ff};
         end
         ST_DYM: begin
            mul_a = 33'(req_ff.y_offset);
            mul_b = {17'd0, sens_ff};
         end
         ST_FMUL0: begin
            mul_a = 33'(cos_h_ff);
            mul_b = 33'(cos_e_ff);
         end
         ST_FMUL1: begin
            mul_a = 33'(sin_h_ff);
            mul_b = 33'(cos_e_ff);
         end
         ST_NSQ: begin
            mul_a = mag_k;
            mul_b = mag_k;
         end
         ST_UMUL0: begin
            mul_a = 33'(right_ff[2]);
            mul_b = 33'(front_ff[1]);
         end
         ST_UMUL1: begin
            mul_a = 33'(right_ff[2]);
            mul_b = 33'(front_ff[0]);
         end
         ST_UMUL2: begin
            mul_a = 33'(right_ff[0]);
            mul_b = 33'(front_ff[2]);
         end
         ST_UMUL3: begin
            mul_a = 33'(right_ff[0]);
            mul_b = 33'(front_ff[1]);
         end
         ST_MV0: begin
            mul_a = mv_neg ? -33'(mv_dir) : 33'(mv_dir);
            mul_b = {17'd0, speed_ff};
         end
         ST_MV1: begin
            mul_a = prod_ff[32:0];
            mul_b = {17'd0, req_ff.step_time};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // heading wrap, elevation clamp, cordic reduction and step
   always_comb begin
      elev_sum = 34'(elev_ff) + 34'(prod_ff);
      if (elev_sum > ELEV_MAX) begin
         elev_in = ELEV_MAX;
      end else if (elev_sum < -ELEV_MAX) begin
         elev_in = -ELEV_MAX;
      end else begin
         elev_in = elev_sum;
      end
      wrap_d   = 34'(DEG360) <<< cnt_ff[2:0];
      wrap_sub = ang_ff - wrap_d;
      ang_in   = (ang_ff >= wrap_d) ? wrap_sub : ang_ff;

      red_a0 = sel_ff ? 27'(elev_ff) : 27'({2'b00, heading_ff});
      red_a1 = (red_a0 >= DEG180) ? red_a0 - DEG360 : red_a0;
      red_neg = 1'b0;
      red_in  = red_a1;
      if (red_a1 > DEG90) begin
         red_in  = red_a1 - DEG180;
         red_neg = 1'b1;
      end else if (red_a1 < -DEG90) begin
         red_in  = red_a1 + DEG180;
         red_neg = 1'b1;
      end

      cx_dx = y_ff >>> cnt_ff;
      cx_dy = x_ff >>> cnt_ff;
      c_at  = 27'({4'd0, atan_q16(cnt_ff)});
   end

   // square root, division and normalised component
   always_comb begin
      acc_in  = acc_ff + prod_ff[63:0];
      sq_bit  = 64'd1 << {cnt_ff, 1'b0};
      sq_try  = root_ff + sq_bit;
      root_n  = root_ff[32:0];
      div_d   = 47'(root_n) << cnt_ff[3:0];
      q_clamp = (quo_ff > 15'(VEC_ONE)) ? VEC_ONE : {1'b0, quo_ff};
      if (root_n == 33'd0) begin
         norm_out = '0;
      end else if (raw_k[32]) begin
         norm_out = -q_clamp;
      end else begin
         norm_out = q_clamp;
      end
   end

   // position update with rounding and saturation
   always_comb begin
      mv_rnd   = (prod_ff + 66'sd2097152) >>> 22;
      mv_delta = mv_rnd[26:0];
      mv_sum   = SW'(pos_ff[k_ff]) + SW'(mv_delta);
      if (mv_sum > PMAX) begin
         pos_in = PMAX;
      end else if (mv_sum < PMIN) begin
         pos_in = PMIN;
      end else begin
         pos_in = mv_sum;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_ROTATE: state_in = ST_DXM;
                  KIND_FORWARD, KIND_BACKWARD, KIND_LEFT, KIND_RIGHT: state_in = ST_MV0;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DXM:       state_in = ST_DYM;
         ST_DYM:       state_in = ST_WRAP_INIT;
         ST_WRAP_INIT: state_in = ST_WRAP;
         ST_WRAP:      state_in = (cnt_ff == 5'd0) ? ST_CINIT : ST_WRAP;
         ST_CINIT:     state_in = ST_CIT;
         ST_CIT:       state_in = (cnt_ff == 5'(CORDIC_STEPS - 1)) ? ST_CEND : ST_CIT;
         ST_CEND:      state_in = sel_ff ? ST_FMUL0 : ST_CINIT;
         ST_FMUL0:     state_in = ST_FMUL1;
         ST_FMUL1:     state_in = ST_FSET;
         ST_FSET:      state_in = ST_NSQ;
         ST_NSQ:       state_in = ST_NACC;
         ST_NACC:      state_in = (k_ff == 2'd2) ? ST_SQRT : ST_NSQ;
         ST_SQRT:      state_in = (cnt_ff == 5'd0) ? ST_DINIT : ST_SQRT;
         ST_DINIT:     state_in = ST_DIV;
         ST_DIV:       state_in = (cnt_ff == 5'd0) ? ST_DEND : ST_DIV;
         ST_DEND: begin
            if (k_ff != 2'd2) begin
               state_in = ST_DINIT;
            end else begin
               case (nsel_ff)
                  NV_FRONT: state_in = ST_RSET;
                  NV_RIGHT: state_in = ST_UMUL0;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_RSET:      state_in = ST_NSQ;
         ST_UMUL0:     state_in = ST_UMUL1;
         ST_UMUL1:     state_in = ST_UMUL2;
         ST_UMUL2:     state_in = ST_UMUL3;
         ST_UMUL3:     state_in = ST_USET;
         ST_USET:      state_in = ST_NSQ;
         ST_MV0:       state_in = ST_MV1;
         ST_MV1:       state_in = ST_MV2;
         ST_MV2:       state_in = (k_ff == 2'd2) ? ST_DONE : ST_MV0;
         ST_DONE:      state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // multiplier output register
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         nsel_ff      <= NV_FRONT;
         rsp_valid_ff <= 1'b0;
         sens_ff      <= SENSITIVITY_RESET;
         speed_ff     <= SPEED_RESET;
         heading_ff   <= HEADING_RESET;
         elev_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
         front_ff[0] <= '0;
         front_ff[1] <= '0;
         front_ff[2] <= -VEC_ONE;
         right_ff[0] <= VEC_ONE;
         right_ff[1] <= '0;
         right_ff[2] <= '0;
         up_ff[0]    <= '0;
         up_ff[1]    <= VEC_ONE;
         up_ff[2]    <= '0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_SENSITIVITY: sens_ff  <= csr_wdata;
               CSR_SPEED:       speed_ff <= csr_wdata;
               default:         sens_ff  <= sens_ff;
            endcase
         end

         // result register loads on completion, drains on handshake
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  k_ff   <= '0;
               end
            end
            ST_DYM: begin
               ang_ff <= 34'({1'b0, heading_ff}) + 34'(prod_ff);
            end
            ST_WRAP_INIT: begin
               elev_ff <= elev_in[23:0];
               if (ang_ff < 0) begin
                  ang_ff <= ang_ff + (34'(DEG360) <<< 7);
               end
               cnt_ff <= 5'd7;
            end
            ST_WRAP: begin
               ang_ff <= ang_in;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  heading_ff <= ang_in[24:0];
                  sel_ff     <= 1'b0;
               end
            end
            ST_CINIT: begin
               x_ff   <= CORDIC_START;
               y_ff   <= '0;
               z_ff   <= red_in;
               neg_ff <= red_neg;
               cnt_ff <= '0;
            end
            ST_CIT: begin
               if (z_ff >= 0) begin
                  x_ff <= x_ff - cx_dx;
                  y_ff <= y_ff + cx_dy;
                  z_ff <= z_ff - c_at;
               end else begin
                  x_ff <= x_ff + cx_dx;
                  y_ff <= y_ff - cx_dy;
                  z_ff <= z_ff + c_at;
               end
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_CEND: begin
               if (sel_ff) begin
                  cos_e_ff <= neg_ff ? -x_ff : x_ff;
                  sin_e_ff <= neg_ff ? -y_ff : y_ff;
               end else begin
                  cos_h_ff <= neg_ff ? -x_ff : x_ff;
                  sin_h_ff <= neg_ff ? -y_ff : y_ff;
               end
               sel_ff <= 1'b1;
            end
            ST_FMUL1: begin
               raw_ff[0] <= 33'(prod_ff >>> 30);
            end
            ST_FSET: begin
               raw_ff[2] <= 33'(prod_ff >>> 30);
               raw_ff[1] <= 33'(sin_e_ff);
               nsel_ff   <= NV_FRONT;
               k_ff      <= '0;
               acc_ff    <= '0;
            end
            ST_NACC: begin
               acc_ff <= acc_in;
               if (k_ff == 2'd2) begin
                  root_ff <= '0;
                  cnt_ff  <= 5'd31;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            ST_SQRT: begin
               if (acc_ff >= sq_try) begin
                  acc_ff  <= acc_ff - sq_try;
                  root_ff <= (root_ff >> 1) + sq_bit;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               cnt_ff <= cnt_ff - 5'd1;
               k_ff   <= '0;
            end
            ST_DINIT: begin
               rem_ff <= ({15'd0, mag_k[31:0]} << 14) + 47'(root_n >> 1);
               quo_ff <= '0;
               cnt_ff <= 5'd14;
            end
            ST_DIV: begin
               if (rem_ff >= div_d) begin
                  rem_ff <= rem_ff - div_d;
                  quo_ff <= quo_ff | (15'd1 << cnt_ff[3:0]);
               end
               cnt_ff <= cnt_ff - 5'd1;
            end
            ST_DEND: begin
               case (nsel_ff)
                  NV_FRONT: front_ff[k_ff] <= norm_out;
                  NV_RIGHT: right_ff[k_ff] <= norm_out;
                  default:  up_ff[k_ff]    <= norm_out;
               endcase
               k_ff <= k_ff + 2'd1;
            end
            ST_RSET: begin
               raw_ff[0] <= -(33'(front_ff[2]) <<< 16);
               raw_ff[1] <= '0;
               raw_ff[2] <= 33'(front_ff[0]) <<< 16;
               nsel_ff   <= NV_RIGHT;
               k_ff      <= '0;
               acc_ff    <= '0;
            end
            ST_UMUL1: begin
               raw_ff[0] <= -(33'(prod_ff) <<< 2);
            end
            ST_UMUL2: begin
               raw_ff[2] <= 33'(prod_ff);
            end
            ST_UMUL3: begin
               raw_ff[1] <= (raw_ff[2] - 33'(prod_ff)) <<< 2;
            end
            ST_USET: begin
               raw_ff[2] <= 33'(prod_ff) <<< 2;
               nsel_ff   <= NV_UP;
               k_ff      <= '0;
               acc_ff    <= '0;
            end
            ST_MV2: begin
               pos_ff[k_ff] <= pos_in[POSITION_WIDTH-1:0];
               k_ff         <= k_ff + 2'd1;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.pos_x    <= 32'(pos_ff[0]);
                  rsp_ff.pos_y    <= 32'(pos_ff[1]);
                  rsp_ff.pos_z    <= 32'(pos_ff[2]);
                  rsp_ff.front_x  <= front_ff[0];
                  rsp_ff.front_y  <= front_ff[1];
                  rsp_ff.front_z  <= front_ff[2];
                  rsp_ff.right_x  <= right_ff[0];
                  rsp_ff.right_y  <= right_ff[1];
                  rsp_ff.right_z  <= right_ff[2];
                  rsp_ff.up_x     <= up_ff[0];
                  rsp_ff.up_y     <= up_ff[1];
                  rsp_ff.up_z     <= up_ff[2];
               end
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

endmodule

// ===== src/ypc_checker.sv =====
module ypc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ypc_pkg::ypc_rsp_type rsp_data
);
   import ypc_pkg::*;

   // no result is shown straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: ready drops after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after an item was taken");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind yaw_pitch_camera_update ypc_checker u_ypc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
